@@ rtl/mnfp_pkg.sv @@
package mnfp_pkg;

    typedef enum logic [2:0] {
        ST_UNKNOWN    = 3'd0,
        ST_ONE        = 3'd1,
        ST_ONE_CONT   = 3'd2,
        ST_TWO_FIRST  = 3'd3,
        ST_TWO_SECOND = 3'd4,
        ST_TWO_DONE   = 3'd5,
        ST_SYSEX      = 3'd6
    } mnfp_state_t;

    localparam int FREQ_W = 14;
    localparam int NOTE_W = 7;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] REALTIME_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] SYSEX_START  = 8'hF0;
    localparam logic [BYTE_W-1:0] SONG_SELECT  = 8'hF1;
    localparam logic [BYTE_W-1:0] SONG_POS     = 8'hF2;
    localparam logic [BYTE_W-1:0] TIME_CODE    = 8'hF3;
    localparam logic [BYTE_W-1:0] ONE_PARAM_LO = 8'hC0;
    localparam logic [BYTE_W-1:0] ONE_PARAM_HI = 8'hDF;

    typedef struct packed {
        logic              emit;
        logic [FREQ_W-1:0] freq;
        logic [BYTE_W-1:0] status;
        logic [NOTE_W-1:0] note;
    } mnfp_result_t;

    // Rounded equal-tempered frequency per note, notes below 12 read as zero
    localparam logic [FREQ_W-1:0] FREQ_TABLE [0:127] = '{
        14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
        14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
        14'd16, 14'd17, 14'd18, 14'd19, 14'd21, 14'd22,
        14'd23, 14'd25, 14'd26, 14'd28, 14'd29, 14'd31,
        14'd33, 14'd35, 14'd37, 14'd39, 14'd41, 14'd44,
        14'd46, 14'd49, 14'd52, 14'd55, 14'd58, 14'd62,
        14'd65, 14'd69, 14'd73, 14'd78, 14'd82, 14'd87,
        14'd93, 14'd98, 14'd104, 14'd110, 14'd117, 14'd123,
        14'd131, 14'd139, 14'd147, 14'd156, 14'd165, 14'd175,
        14'd185, 14'd196, 14'd208, 14'd220, 14'd233, 14'd247,
        14'd262, 14'd277, 14'd294, 14'd311, 14'd330, 14'd349,
        14'd370, 14'd392, 14'd415, 14'd440, 14'd466, 14'd494,
        14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698,
        14'd740, 14'd784, 14'd831, 14'd880, 14'd932, 14'd988,
        14'd1047, 14'd1109, 14'd1175, 14'd1245, 14'd1319, 14'd1397,
        14'd1480, 14'd1568, 14'd1661, 14'd1760, 14'd1865, 14'd1976,
        14'd2093, 14'd2218, 14'd2349, 14'd2489, 14'd2637, 14'd2794,
        14'd2960, 14'd3136, 14'd3322, 14'd3520, 14'd3729, 14'd3951,
        14'd4186, 14'd4435, 14'd4699, 14'd4978, 14'd5274, 14'd5588,
        14'd5920, 14'd6272, 14'd6645, 14'd7040, 14'd7459, 14'd7902,
        14'd8372, 14'd8870, 14'd9397, 14'd9956, 14'd10548, 14'd11175,
        14'd11840, 14'd12544
    };

endpackage

@@ rtl/midi_note_frequency_parser.sv @@
// An accepted MIDI byte goes to the input register, then its note word to the
// output register. Throughput: one byte per cycle while the output is not stalled; the
// parser step and table lookup sit between the input register and the output register.
// Reset (rst_n, asynchronous, active low): parser in unknown state, held status and
// note cleared, both pipeline registers empty.
module midi_note_frequency_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        midi_valid,
    output logic        midi_stall,
    input  logic [7:0]  midi_byte,
    output logic        note_valid,
    input  logic        note_stall,
    output logic [13:0] frequency_hz,
    output logic [7:0]  status_byte,
    output logic [6:0]  note_number
);
    import mnfp_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [FREQ_W-1:0] freq_reg;
    logic [BYTE_W-1:0] status_reg;
    logic [NOTE_W-1:0] note_reg;
    logic              advance;
    logic              step;
    logic              take;
    mnfp_result_t      result;

    assign advance    = !out_valid_reg || !note_stall;
    assign step       = in_valid_reg && advance;
    assign midi_stall = in_valid_reg && !advance;
    assign take       = midi_valid && !midi_stall;

    mnfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .midi_byte (in_byte_reg),
        .result    (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = step && result.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: load on a new word, hold while stalled
    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= midi_byte;
        if (step && result.emit)
        begin
            freq_reg   <= result.freq;
            status_reg <= result.status;
            note_reg   <= result.note;
        end
    end

    assign note_valid   = out_valid_reg;
    assign frequency_hz = freq_reg;
    assign status_byte  = status_reg;
    assign note_number  = note_reg;

endmodule

@@ rtl/mnfp_parser.sv @@
module mnfp_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   midi_byte,
    output mnfp_pkg::mnfp_result_t       result
);
    import mnfp_pkg::*;

    mnfp_state_t       state_reg;
    mnfp_state_t       state_next;
    logic [BYTE_W-1:0] held_status_reg;
    logic [BYTE_W-1:0] held_status_next;
    logic [NOTE_W-1:0] held_note_reg;
    logic [NOTE_W-1:0] held_note_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_UNKNOWN;
            held_status_reg <= '0;
            held_note_reg   <= '0;
        end
        else if (step)
        begin
            state_reg       <= state_next;
            held_status_reg <= held_status_next;
            held_note_reg   <= held_note_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        held_status_next = held_status_reg;
        held_note_next   = held_note_reg;
        if (midi_byte >= REALTIME_MIN)
        begin
            // real-time: leave everything as it is
        end
        else if (midi_byte >= SYSEX_START)
        begin
            case (midi_byte)
                SYSEX_START: state_next = ST_SYSEX;
                SONG_SELECT: state_next = ST_ONE;
                TIME_CODE:   state_next = ST_ONE;
                SONG_POS:    state_next = ST_TWO_FIRST;
                default:     state_next = ST_UNKNOWN;
            endcase
        end
        else if (midi_byte[7])
        begin
            if (midi_byte inside {[ONE_PARAM_LO:ONE_PARAM_HI]})
            begin
                state_next = ST_ONE;
            end
            else
            begin
                state_next       = ST_TWO_FIRST;
                held_status_next = midi_byte;
            end
        end
        else
        begin
            case (state_reg)
                ST_ONE:        state_next = ST_ONE_CONT;
                ST_TWO_FIRST:
                begin
                    state_next     = ST_TWO_SECOND;
                    held_note_next = midi_byte[NOTE_W-1:0];
                end
                ST_TWO_SECOND: state_next = ST_TWO_DONE;
                // running status: next data byte starts a fresh pair but keeps the held note
                ST_TWO_DONE:   state_next = ST_TWO_SECOND;
                default:       state_next = state_reg;
            endcase
        end
    end

    always_comb
    begin
        result.emit   = (state_next == ST_TWO_DONE);
        result.freq   = FREQ_TABLE[held_note_next];
        result.status = held_status_next;
        result.note   = held_note_next;
    end

endmodule
